// File: rtl/ci64alu_pkg.sv
// Shared types, opcodes and helpers for the checked signed 64-bit ALU.
// Used by front end, queue, back end and top level.
package ci64alu_pkg;
	localparam int unsigned W          = 64;
	localparam int unsigned DIV_STEPS  = W;
	localparam int unsigned FIFO_DEPTH = 2;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_REM = 3'd4
	} op_t;

	// Classified item: operands, magnitudes, signs and a reject flag.
	typedef struct packed {
		logic [2:0]   op;
		logic [W-1:0] a;
		logic [W-1:0] b;
		logic [W-1:0] ma;
		logic [W-1:0] mb;
		logic         sa;
		logic         sb;
		logic         bad;
	} item_t;

	// Record carried down the execution pipeline.
	typedef struct packed {
		logic [2:0]   op;
		logic [W-1:0] res;
		logic         ok;
		logic [W-1:0] rem;
		logic [W-1:0] dq;
		logic [W-1:0] mb;
		logic         sa;
		logic         sb;
		logic         bad;
	} stg_t;

	typedef struct packed {
		logic [W-1:0] rem;
		logic [W-1:0] dq;
	} divs_t;

	function automatic logic [W-1:0] magnitude(input logic [W-1:0] x);
		return x[W-1] ? (~x + {{(W-1){1'b0}}, 1'b1}) : x;
	endfunction

	// One restoring division step: shift in the next dividend bit, try subtract.
	function automatic divs_t div_step(input logic [W-1:0] rem, input logic [W-1:0] dq,
			input logic [W-1:0] mb);
		logic [W:0] trial;
		logic [W:0] diff;
		divs_t      o;
		trial = {rem, dq[W-1]};
		diff  = trial - {1'b0, mb};
		if (!diff[W]) begin
			o.rem = diff[W-1:0];
			o.dq  = {dq[W-2:0], 1'b1};
		end else begin
			o.rem = trial[W-1:0];
			o.dq  = {dq[W-2:0], 1'b0};
		end
		return o;
	endfunction
endpackage

// File: rtl/ci64alu_front.sv
// Front end: accepts input beats and classifies them for the back end.
// Depends on ci64alu_pkg.
module ci64alu_front (
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [2:0]                    operation,
	input  logic signed [ci64alu_pkg::W-1:0] lhs,
	input  logic signed [ci64alu_pkg::W-1:0] rhs,
	output logic                          push,
	input  logic                          q_full,
	output ci64alu_pkg::item_t            item
);
	import ci64alu_pkg::*;

	logic [W-1:0] a;
	logic [W-1:0] b;
	logic         is_div;
	logic         known;

	assign a        = lhs;
	assign b        = rhs;
	assign in_ready = !q_full;
	assign push     = in_valid && !q_full;

	always_comb begin
		is_div = (operation == OP_DIV) || (operation == OP_REM);
		known  = operation inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_REM};
		item.op  = operation;
		item.a   = a;
		item.b   = b;
		item.ma  = magnitude(a);
		item.mb  = magnitude(b);
		item.sa  = a[W-1];
		item.sb  = b[W-1];
		// reject zero divisor, minimum over minus one, and unknown codes
		item.bad = !known || (is_div && ((b == '0) ||
			((a == {1'b1, {(W-1){1'b0}}}) && (b == '1))));
	end
endmodule

// File: rtl/ci64alu_fifo.sv
// Short queue between front end and back end.
// Depends on ci64alu_pkg.
module ci64alu_fifo #(
	parameter int unsigned DEPTH = ci64alu_pkg::FIFO_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  ci64alu_pkg::item_t push_data,
	output logic               full,
	input  logic               pop,
	output logic               not_empty,
	output ci64alu_pkg::item_t head
);
	import ci64alu_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	item_t         mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	assign full      = (cnt_q == CW'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty) else $error("queue underflow");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == $past(cnt_q) + CW'(1))) else $error("count slip");
endmodule

// File: rtl/ci64alu_back.sv
// Back end: pipelined add/sub, split multiplier and one-bit-per-stage divider.
// Depends on ci64alu_pkg.
module ci64alu_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_valid,
	input  ci64alu_pkg::item_t         q_head,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [ci64alu_pkg::W-1:0] value,
	output logic                       valid_res
);
	import ci64alu_pkg::*;

	localparam int unsigned D = DIV_STEPS;
	localparam int unsigned H = W / 2;
	localparam logic [W-1:0] MIN_V = {1'b1, {(W-1){1'b0}}};

	logic         adv;
	logic         vld_q [1:D];
	stg_t         stage_s [1:D];
	logic [W-1:0] pp_s1 [4];
	logic [2*W-1:0] prod_s2;
	logic         out_v_q;
	logic [W-1:0] value_q;
	logic         ok_q;

	stg_t         first;
	divs_t        d0;
	logic [W:0]   sum_w;
	logic [W:0]   dif_w;
	logic [W-1:0] fin_res;
	logic         fin_ok;
	stg_t         last;

	// whole pipe moves together whenever the output slot can take a beat
	assign adv       = !out_v_q || out_ready;
	assign pop       = adv && q_valid;
	assign out_valid = out_v_q;
	assign value     = value_q;
	assign valid_res = ok_q;

	always_comb begin
		sum_w = {1'b0, q_head.a} + {1'b0, q_head.b};
		dif_w = {1'b0, q_head.a} - {1'b0, q_head.b};
		d0    = div_step('0, q_head.ma, q_head.mb);
		first.op  = q_head.op;
		first.rem = d0.rem;
		first.dq  = d0.dq;
		first.mb  = q_head.mb;
		first.sa  = q_head.sa;
		first.sb  = q_head.sb;
		first.bad = q_head.bad;
		first.res = '0;
		first.ok  = 1'b0;
		if (q_head.op == OP_ADD) begin
			first.res = sum_w[W-1:0];
			first.ok  = !((q_head.a[W-1] ^ sum_w[W-1]) & (q_head.b[W-1] ^ sum_w[W-1]));
		end else if (q_head.op == OP_SUB) begin
			first.res = dif_w[W-1:0];
			first.ok  = !((q_head.a[W-1] ^ q_head.b[W-1]) & (q_head.a[W-1] ^ dif_w[W-1]));
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			stage_s[1] <= first;
			pp_s1[0]   <= {{H{1'b0}}, q_head.ma[H-1:0]} * {{H{1'b0}}, q_head.mb[H-1:0]};
			pp_s1[1]   <= {{H{1'b0}}, q_head.ma[H-1:0]} * {{H{1'b0}}, q_head.mb[W-1:H]};
			pp_s1[2]   <= {{H{1'b0}}, q_head.ma[W-1:H]} * {{H{1'b0}}, q_head.mb[H-1:0]};
			pp_s1[3]   <= {{H{1'b0}}, q_head.ma[W-1:H]} * {{H{1'b0}}, q_head.mb[W-1:H]};
			prod_s2    <= {pp_s1[3], pp_s1[0]}
				+ {{H{1'b0}}, pp_s1[1], {H{1'b0}}}
				+ {{H{1'b0}}, pp_s1[2], {H{1'b0}}};
		end
	end

	for (genvar k = 2; k <= D; k++) begin : g_stage
		stg_t  nxt;
		divs_t ds;
		always_comb begin
			ds  = div_step(stage_s[k-1].rem, stage_s[k-1].dq, stage_s[k-1].mb);
			nxt = stage_s[k-1];
			nxt.rem = ds.rem;
			nxt.dq  = ds.dq;
			if (k == 3 && stage_s[k-1].op == OP_MUL) begin
				nxt.ok = 1'b0;
				nxt.res = prod_s2[W-1:0];
				if (prod_s2[2*W-1:W] == '0) begin
					if (stage_s[k-1].sa != stage_s[k-1].sb) begin
						nxt.ok  = (prod_s2[W-1:0] <= MIN_V);
						nxt.res = ~prod_s2[W-1:0] + W'(1);
					end else begin
						nxt.ok  = (prod_s2[W-1:0] < MIN_V);
					end
				end
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				stage_s[k] <= nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= D; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else if (adv) begin
			vld_q[1] <= q_valid;
			for (int i = 2; i <= D; i++) begin
				vld_q[i] <= vld_q[i-1];
			end
		end
	end

	always_comb begin
		last    = stage_s[D];
		fin_res = '0;
		fin_ok  = 1'b0;
		case (last.op)
			OP_ADD, OP_SUB, OP_MUL: begin
				fin_ok  = last.ok;
				fin_res = last.ok ? last.res : '0;
			end
			OP_DIV: begin
				fin_ok  = !last.bad;
				fin_res = last.bad ? '0 : ((last.sa != last.sb) ? (~last.dq + W'(1)) : last.dq);
			end
			OP_REM: begin
				fin_ok  = !last.bad;
				fin_res = last.bad ? '0 : (last.sa ? (~last.rem + W'(1)) : last.rem);
			end
			default: begin
				fin_ok  = 1'b0;
				fin_res = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			value_q <= fin_res;
			ok_q    <= fin_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= vld_q[D];
		end
	end

	a_zero_when_bad: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !ok_q) |-> (value_q == '0)) else $error("rejected result not zero");
	a_pipe_shift: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> (vld_q[2] == $past(vld_q[1]))) else $error("pipe valid lost");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> (vld_q[1] == $past(vld_q[1]))) else $error("pipe moved while stalled");
endmodule

// File: rtl/checked_int64_alu_top.sv
// Overflow-checked signed 64-bit ALU: add, sub, mul, div, rem with valid flag.
// Path from input beat to output beat: queue, 64 divider stages, out reg.
// Throughput: one beat per cycle unless out_ready stalls the pipe; the 64-stage divider pipeline sets the latency.
// Multiply uses four 32x32 partial products and a 128-bit sum stage.
// Reset clears queue pointers and count and the pipeline and output valid bits only.
// Depends on ci64alu_pkg, ci64alu_front, ci64alu_fifo, ci64alu_back.
module checked_int64_alu_top #(
	parameter int unsigned FIFO_DEPTH = ci64alu_pkg::FIFO_DEPTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [2:0]                       operation,
	input  logic signed [ci64alu_pkg::W-1:0] lhs,
	input  logic signed [ci64alu_pkg::W-1:0] rhs,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [ci64alu_pkg::W-1:0] value,
	output logic                             valid_res
);
	import ci64alu_pkg::*;

	logic  push;
	logic  q_full;
	logic  q_valid;
	logic  pop;
	item_t item;
	item_t head;

	ci64alu_front u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.operation(operation),
		.lhs      (lhs),
		.rhs      (rhs),
		.push     (push),
		.q_full   (q_full),
		.item     (item)
	);

	ci64alu_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(item),
		.full     (q_full),
		.pop      (pop),
		.not_empty(q_valid),
		.head     (head)
	);

	ci64alu_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_head   (head),
		.pop      (pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.value    (value),
		.valid_res(valid_res)
	);
endmodule
